>>> design/timing_wheel_slot_balancer_unit_assert.svh
// Assertion macros for the timing wheel slot balancer checker
`ifndef TIMING_WHEEL_SLOT_BALANCER_UNIT_ASSERT_SVH
`define TIMING_WHEEL_SLOT_BALANCER_UNIT_ASSERT_SVH

// Check a same-cycle implication on the clock, off while in reset
`define TWSB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twsb checker: same-cycle implication violated");

// Check a next-cycle implication on the clock, off while in reset
`define TWSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twsb checker: next-cycle implication violated");

`endif

>>> design/twsb_pkg.sv
// Shared constants, types and helper functions of the timing wheel slot balancer
package twsb_pkg;

    localparam int SLOTS      = 64;
    localparam int COUNT_BITS = 8;
    localparam int SLOT_BITS  = $clog2(SLOTS);

    localparam int DELAY_W  = 16;
    localparam int SLEEP_W  = 6;
    localparam int HINT_W   = 7;
    localparam int CHOSEN_W = 6;
    localparam int DRAIN_W  = 8;

    // slot plus offset always fits in 17 bits for SLOTS up to 1024
    localparam int SUM_W     = DELAY_W + 1;
    localparam int MOD_STEPS = SUM_W - SLOT_BITS + 1;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [SLEEP_W-1:0]    sleep_t;
    typedef logic [HINT_W-1:0]     hint_t;

    localparam sleep_t MAX_SLEEP_RST = 6'd19;
    localparam count_t COUNT_MAX     = {COUNT_BITS{1'b1}};
    localparam slot_t  LAST_SLOT     = SLOT_BITS'(SLOTS - 1);

    function automatic slot_t slot_inc(input slot_t s);
        return (s == LAST_SLOT) ? '0 : slot_t'(s + 1'b1);
    endfunction

    function automatic slot_t slot_dec(input slot_t s);
        return (s == '0) ? LAST_SLOT : slot_t'(s - 1'b1);
    endfunction

    function automatic logic [DRAIN_W-1:0] to_drain(input count_t c);
        if (32'(c) > 32'd255)
        begin
            return 8'hFF;
        end
        return DRAIN_W'(c);
    endfunction

endpackage

>>> design/twsb_ram.sv
// Generic single-write, single-read RAM with registered read data
module twsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/twsb_modstep.sv
// One restoring step of the slot-count modulo reducer
module twsb_modstep import twsb_pkg::*; (
    input  sum_t  rem,
    input  step_t shift,
    output sum_t  rem_out
);

    sum_t divisor;

    // compare against SLOTS scaled by 2^shift, subtract when it fits
    assign divisor = sum_t'(SLOTS) << shift;
    assign rem_out = (rem >= divisor) ? sum_t'(rem - divisor) : rem;

endmodule

>>> design/timing_wheel_slot_balancer_unit.sv
// Timing wheel slot balancer: tick drain and balanced schedule under one sequencer
// Schedule adds MOD_STEPS (12 at 64 slots) reduction steps when the target wraps.
// Throughput: one word at a time; busy stays high until done strobes, set by the
//   one-slot-per-cycle nearest-busy scan and the single count RAM read port.
// Reset: counts read as zero through per-slot valid bits, pointer 0, max_sleep 19.
// done strobes one cycle per word; the receiver has no way to stall it.
module timing_wheel_slot_balancer_unit import twsb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic                operation,
    input  logic [DELAY_W-1:0]  delay_ticks,
    input  logic                initial_req,
    output logic [CHOSEN_W-1:0] chosen_slot,
    output logic [DRAIN_W-1:0]  drained_count,
    output logic [HINT_W-1:0]   sleep_ticks,
    output logic                count_saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SLEEP_W-1:0]  cfg_data
);

    // sequencer codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_TICK_RD = 4'd1;
    localparam logic [3:0] ST_TICK_WR = 4'd2;
    localparam logic [3:0] ST_MOD     = 4'd3;
    localparam logic [3:0] ST_RD_T    = 4'd4;
    localparam logic [3:0] ST_RD_P    = 4'd5;
    localparam logic [3:0] ST_RD_N    = 4'd6;
    localparam logic [3:0] ST_PICK    = 4'd7;
    localparam logic [3:0] ST_SCAN    = 4'd8;

    // balancing choice codes
    localparam logic [1:0] PICK_TGT  = 2'd0;
    localparam logic [1:0] PICK_PREV = 2'd1;
    localparam logic [1:0] PICK_NEXT = 2'd2;

    // control state
    logic [3:0]       state_reg, state_next;
    slot_t            cur_reg, cur_next;
    sleep_t           ms_reg, ms_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    slot_t            iss_pos_reg, iss_pos_next;
    sleep_t           iss_cnt_reg, iss_cnt_next;
    sleep_t           chk_reg, chk_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;

    // payload state
    slot_t                real_reg, real_next;
    sum_t                 rem_reg, rem_next;
    step_t                step_reg, step_next;
    count_t               cnt_t_reg, cnt_t_next;
    count_t               cnt_p_reg, cnt_p_next;
    logic                 rd_valid_reg;
    logic [CHOSEN_W-1:0]  chosen_reg, chosen_next;
    logic [DRAIN_W-1:0]   drained_reg, drained_next;
    hint_t                hint_reg, hint_next;
    logic                 sat_reg, sat_next;

    // datapath
    sum_t   offset;
    sum_t   sum_acc;
    sum_t   rem_step;
    slot_t  red_slot;
    slot_t  clamp_slot;
    slot_t  prev_slot;
    slot_t  next_slot;
    slot_t  raddr;
    count_t ram_rdata;
    count_t rq_eff;
    logic [1:0] which;
    slot_t  pick_slot;
    count_t pick_cnt;
    logic   pick_sat;
    count_t pick_wdata;
    logic   ram_we;
    logic   scan_issue;
    sleep_t chk_inc;

    // Target offset: delay minus one, floored at 0 for new entries and 1 otherwise
    always_comb
    begin
        if (delay_ticks <= DELAY_W'(1))
        begin
            offset = initial_req ? '0 : sum_t'(1);
        end
        else
        begin
            offset = sum_t'(delay_ticks - 1'b1);
        end
    end

    assign sum_acc = sum_t'(cur_reg) + offset;

    // Shared compare-subtract unit: one quotient bit per cycle while wrapping
    twsb_modstep u_modstep (
        .rem     (rem_reg),
        .shift   (step_reg),
        .rem_out (rem_step)
    );

    // Clamp a wrapped target that lands on or past the pointer to the slot before it
    assign red_slot   = rem_step[SLOT_BITS-1:0];
    assign clamp_slot = (red_slot >= cur_reg) ? slot_dec(cur_reg) : red_slot;

    assign prev_slot = slot_dec(real_reg);
    assign next_slot = slot_inc(real_reg);

    // Never-written slots read as zero through their valid bit
    assign rq_eff = rd_valid_reg ? ram_rdata : '0;

    // Least-loaded neighbor; ties keep the target, then prefer the previous slot
    always_comb
    begin
        if (cnt_t_reg <= cnt_p_reg)
        begin
            which = (cnt_t_reg <= rq_eff) ? PICK_TGT : PICK_NEXT;
        end
        else
        begin
            which = (cnt_p_reg <= rq_eff) ? PICK_PREV : PICK_NEXT;
        end

        // Never move onto the current slot: keep the target then
        if (which == PICK_PREV && prev_slot != cur_reg)
        begin
            pick_slot = prev_slot;
            pick_cnt  = cnt_p_reg;
        end
        else if (which == PICK_NEXT && next_slot != cur_reg)
        begin
            pick_slot = next_slot;
            pick_cnt  = rq_eff;
        end
        else
        begin
            pick_slot = real_reg;
            pick_cnt  = cnt_t_reg;
        end
    end

    // Saturate a full slot instead of wrapping its count
    assign pick_sat   = (pick_cnt == COUNT_MAX);
    assign pick_wdata = pick_sat ? pick_cnt : count_t'(pick_cnt + 1'b1);
    assign ram_we     = (state_reg == ST_PICK);

    // Read address: one port shared by drain, three-way balance and scan
    always_comb
    begin
        unique case (state_reg)
            ST_TICK_RD: raddr = cur_reg;
            ST_RD_T:    raddr = real_reg;
            ST_RD_P:    raddr = prev_slot;
            ST_RD_N:    raddr = next_slot;
            default:    raddr = iss_pos_reg;
        endcase
    end

    twsb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pick_slot),
        .wdata (pick_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Scan issues one slot read per cycle and checks the one issued the cycle before
    assign scan_issue = (iss_cnt_reg < ms_reg);
    assign chk_inc    = sleep_t'(chk_reg + 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        ms_next      = ms_reg;
        valid_next   = valid_reg;
        iss_pos_next = iss_pos_reg;
        iss_cnt_next = iss_cnt_reg;
        chk_next     = chk_reg;
        pend_next    = pend_reg;
        done_next    = 1'b0;
        real_next    = real_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        cnt_t_next   = cnt_t_reg;
        cnt_p_next   = cnt_p_reg;
        chosen_next  = chosen_reg;
        drained_next = drained_reg;
        hint_next    = hint_reg;
        sat_next     = sat_reg;

        if (cfg_valid && cfg_ready)
        begin
            ms_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation)
                    begin
                        state_next = ST_TICK_RD;
                    end
                    else if (sum_acc < sum_t'(SLOTS))
                    begin
                        real_next  = sum_acc[SLOT_BITS-1:0];
                        state_next = ST_RD_T;
                    end
                    else
                    begin
                        rem_next   = sum_acc;
                        step_next  = step_t'(MOD_STEPS - 1);
                        state_next = ST_MOD;
                    end
                end
            end
            ST_TICK_RD:
            begin
                state_next = ST_TICK_WR;
            end
            ST_TICK_WR:
            begin
                // drain the current slot, advance the pointer, start scanning there
                drained_next       = to_drain(rq_eff);
                chosen_next        = '0;
                sat_next           = 1'b0;
                valid_next[cur_reg] = 1'b0;
                cur_next           = slot_inc(cur_reg);
                iss_pos_next       = slot_inc(cur_reg);
                iss_cnt_next       = '0;
                chk_next           = '0;
                pend_next          = 1'b0;
                state_next         = ST_SCAN;
            end
            ST_MOD:
            begin
                rem_next  = rem_step;
                step_next = step_t'(step_reg - 1'b1);
                if (step_reg == '0)
                begin
                    real_next  = clamp_slot;
                    state_next = ST_RD_T;
                end
            end
            ST_RD_T:
            begin
                state_next = ST_RD_P;
            end
            ST_RD_P:
            begin
                cnt_t_next = rq_eff;
                state_next = ST_RD_N;
            end
            ST_RD_N:
            begin
                cnt_p_next = rq_eff;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                valid_next[pick_slot] = 1'b1;
                chosen_next           = CHOSEN_W'(pick_slot);
                drained_next          = '0;
                sat_next              = pick_sat;
                iss_pos_next          = cur_reg;
                iss_cnt_next          = '0;
                chk_next              = '0;
                pend_next             = 1'b0;
                state_next            = ST_SCAN;
            end
            ST_SCAN:
            begin
                pend_next = scan_issue;
                if (scan_issue)
                begin
                    iss_cnt_next = sleep_t'(iss_cnt_reg + 1'b1);
                    iss_pos_next = slot_inc(iss_pos_reg);
                end

                if (pend_reg && rq_eff != '0)
                begin
                    hint_next  = hint_t'(chk_reg) + hint_t'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (pend_reg)
                begin
                    chk_next = chk_inc;
                    if (chk_inc == ms_reg)
                    begin
                        hint_next  = hint_t'(ms_reg) + hint_t'(1);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (chk_reg == ms_reg)
                begin
                    // max_sleep of zero: nothing to search
                    hint_next  = hint_t'(ms_reg) + hint_t'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: cleared by reset, except max_sleep, which resets to MAX_SLEEP_RST
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            ms_reg      <= MAX_SLEEP_RST;
            valid_reg   <= '0;
            iss_pos_reg <= '0;
            iss_cnt_reg <= '0;
            chk_reg     <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            ms_reg      <= ms_next;
            valid_reg   <= valid_next;
            iss_pos_reg <= iss_pos_next;
            iss_cnt_reg <= iss_cnt_next;
            chk_reg     <= chk_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        real_reg     <= real_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        cnt_t_reg    <= cnt_t_next;
        cnt_p_reg    <= cnt_p_next;
        rd_valid_reg <= valid_reg[raddr];
        chosen_reg   <= chosen_next;
        drained_reg  <= drained_next;
        hint_reg     <= hint_next;
        sat_reg      <= sat_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign cfg_ready       = ~busy;
    assign done            = done_reg;
    assign chosen_slot     = chosen_reg;
    assign drained_count   = drained_reg;
    assign sleep_ticks     = hint_reg;
    assign count_saturated = sat_reg;

endmodule

>>> design/twsb_checker.sv
// Port-level checker for the timing wheel slot balancer, bound to the top level
`include "timing_wheel_slot_balancer_unit_assert.svh"

module twsb_checker import twsb_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [CHOSEN_W-1:0] chosen_slot,
    input logic [DRAIN_W-1:0]  drained_count,
    input logic [HINT_W-1:0]   sleep_ticks,
    input logic                count_saturated
);

    // an accepted word holds the block busy
    `TWSB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a result only ends a busy spell
    `TWSB_ASSERT_IMP(a_done_after_busy, done, $past(busy))
    // hint stays within one to 64, the largest max_sleep plus one
    `TWSB_ASSERT_IMP(a_hint_range, done, (sleep_ticks != 7'd0) && (sleep_ticks <= 7'd64))
    // a nonzero drain result carries no slot and no saturation
    `TWSB_ASSERT_IMP(a_tick_fields, done && (drained_count != 8'd0), (chosen_slot == 6'd0) && !count_saturated)
    // one strobe per word
    `TWSB_ASSERT_NEXT(a_single_strobe, done, !done)

endmodule

bind timing_wheel_slot_balancer_unit twsb_checker u_twsb_checker (.*);
